// File: design/xlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlt_pkg
// Shared types and character, event and kind codes for the XML-lite tokenizer.
// ----------------------------------------------------------------------------
package xlt_pkg;

    typedef logic [7:0] char_t;
    typedef logic [1:0] event_t;
    typedef logic [1:0] kind_t;

    localparam char_t CH_LT    = 8'h3C;  // '<'
    localparam char_t CH_SLASH = 8'h2F;  // '/'
    localparam char_t CH_GT    = 8'h3E;  // '>'
    localparam char_t CH_EQ    = 8'h3D;  // '='
    localparam char_t CH_QUOTE = 8'h22;  // '"'
    localparam char_t CH_QMARK = 8'h3F;  // '?'
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;

    localparam event_t EV_APPEND  = 2'd0;
    localparam event_t EV_END     = 2'd1;
    localparam event_t EV_DISCARD = 2'd2;

    localparam kind_t KIND_TEXT = 2'd0;
    localparam kind_t KIND_ELEM = 2'd1;
    localparam kind_t KIND_ATTR = 2'd2;
    localparam kind_t KIND_VAL  = 2'd3;

    function automatic logic is_ws(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// File: design/xml_lite_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_lite_tokenizer
// Byte-serial lexer for a simplified XML stream with a registered result.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and each byte yields at most one result: a byte
// appended to the current token, a token end tagged with its kind, or a
// discard of a closing-tag name. A byte with no result (markup, whitespace
// between attributes, bytes before an opening quote) is consumed silently.
// The result is registered and appears in the cycle after the transfer, held
// in a single output register, and a new byte is taken whenever that register
// is empty or being drained in the same cycle.
// Bytes of a token still pending when input stops are never flushed.
// ----------------------------------------------------------------------------
module xml_lite_tokenizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  xlt_pkg::char_t byte_in,
    output logic           out_valid,
    input  logic           out_ready,
    output xlt_pkg::event_t event_res,
    output xlt_pkg::kind_t token_kind,
    output xlt_pkg::char_t byte_out
);
    import xlt_pkg::*;

    typedef enum logic [2:0] {
        ST_TEXT  = 3'd0,
        ST_ELEM  = 3'd1,
        ST_ATTR  = 3'd2,
        ST_WAITQ = 3'd3,
        ST_VAL   = 3'd4
    } lex_state_t;

    lex_state_t lex_state_reg, lex_state_next;
    logic       closing_reg, closing_next;
    logic       nonempty_reg, nonempty_next;
    logic       out_valid_reg;
    event_t     event_reg, event_next;
    kind_t      kind_reg, kind_next;
    char_t      byte_reg;
    logic       has_res;
    logic       in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        lex_state_next = lex_state_reg;
        closing_next   = closing_reg;
        nonempty_next  = nonempty_reg;
        has_res        = 1'b0;
        event_next     = EV_APPEND;
        kind_next      = KIND_TEXT;
        case (lex_state_reg)
            ST_ELEM:
            begin
                if (byte_in == CH_SLASH)
                begin
                    closing_next = 1'b1;
                end
                else if (byte_in == CH_GT)
                begin
                    lex_state_next = ST_TEXT;
                    nonempty_next  = 1'b0;
                    has_res        = 1'b1;
                    if (closing_reg)
                    begin
                        closing_next = 1'b0;
                        event_next   = EV_DISCARD;
                    end
                    else
                    begin
                        event_next = EV_END;
                        kind_next  = KIND_ELEM;
                    end
                end
                else if (is_ws(byte_in))
                begin
                    lex_state_next = ST_ATTR;
                    nonempty_next  = 1'b0;
                    has_res        = 1'b1;
                    event_next     = EV_END;
                    kind_next      = KIND_ELEM;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    has_res       = 1'b1;
                end
            end
            ST_ATTR:
            begin
                if (is_ws(byte_in))
                begin
                    has_res = 1'b0;
                end
                else if (byte_in == CH_SLASH || byte_in == CH_QMARK)
                begin
                    closing_next = 1'b1;
                end
                else if (byte_in == CH_GT)
                begin
                    // pending attribute bytes carry over into the next text token
                    lex_state_next = ST_TEXT;
                    closing_next   = 1'b0;
                end
                else if (byte_in == CH_EQ)
                begin
                    lex_state_next = ST_WAITQ;
                    nonempty_next  = 1'b0;
                    has_res        = 1'b1;
                    event_next     = EV_END;
                    kind_next      = KIND_ATTR;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    has_res       = 1'b1;
                end
            end
            ST_WAITQ:
            begin
                if (byte_in == CH_QUOTE)
                begin
                    lex_state_next = ST_VAL;
                end
            end
            ST_VAL:
            begin
                if (byte_in == CH_QUOTE)
                begin
                    lex_state_next = ST_ATTR;
                    nonempty_next  = 1'b0;
                    has_res        = 1'b1;
                    event_next     = EV_END;
                    kind_next      = KIND_VAL;
                end
                else
                begin
                    nonempty_next = 1'b1;
                    has_res       = 1'b1;
                end
            end
            default:
            begin
                lex_state_next = ST_TEXT;
                if (byte_in == CH_LT)
                begin
                    lex_state_next = ST_ELEM;
                    if (nonempty_reg)
                    begin
                        nonempty_next = 1'b0;
                        has_res       = 1'b1;
                        event_next    = EV_END;
                        kind_next     = KIND_TEXT;
                    end
                end
                else
                begin
                    nonempty_next = 1'b1;
                    has_res       = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_state_reg <= ST_TEXT;
            closing_reg   <= 1'b0;
            nonempty_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_APPEND;
            kind_reg      <= KIND_TEXT;
            byte_reg      <= '0;
        end
        else if (in_fire)
        begin
            lex_state_reg <= lex_state_next;
            closing_reg   <= closing_next;
            nonempty_reg  <= nonempty_next;
            out_valid_reg <= has_res;
            event_reg     <= event_next;
            kind_reg      <= kind_next;
            byte_reg      <= byte_in;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign token_kind = kind_reg;
    assign byte_out   = byte_reg;

endmodule
